FILE: hdl/inflight_request_credit_tracker_assert.svh
// Assertion macros for the in-flight tracker datapath.
`ifndef INFLIGHT_REQUEST_CREDIT_TRACKER_ASSERT_SVH
`define INFLIGHT_REQUEST_CREDIT_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define ICT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define ICT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ictrk_pkg.sv
// Shared constants, codes and control types for the in-flight request tracker.
package ictrk_pkg;

	// Default sizes
	localparam int unsigned TABLE_DEPTH_DEF  = 16;
	localparam int unsigned NUM_STREAMS_DEF  = 4;
	localparam int unsigned MAX_RESULTS      = 16;
	localparam int unsigned DRAIN_CNT_W      = $clog2(MAX_RESULTS);

	// Field widths
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned FRAME_W  = 32;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned MASK_W   = 4;
	localparam int unsigned LIMIT_W  = 6;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned STATUS_W = 3;

	// Stream payload layout
	localparam int unsigned IN_TAG_LSB  = FRAME_W;
	localparam int unsigned IN_MASK_LSB = IN_TAG_LSB + TAG_W;
	localparam int unsigned IN_HAS_BIT  = IN_MASK_LSB + MASK_W;
	localparam int unsigned IN_WANT_BIT = IN_HAS_BIT + 1;
	localparam int unsigned IN_DATA_W   = 56;
	localparam int unsigned OUT_USED_W  = STATUS_W + 2 + FRAME_W + TAG_W;
	localparam int unsigned OUT_DATA_W  = 56;
	localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0 = 3'd1;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_STREAM_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TAG_MISMATCH = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_REQUEST = 3'd5;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic compare;
		logic execute;
		logic out_load;
		logic drain_step;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_clear;
		logic out_free;
		logic drain_last;
	} dp_status_t;

endpackage

FILE: hdl/ictrk_ctrl.sv
// Sequencer for the in-flight tracker: accept, compare, execute, result or drain.
module ictrk_ctrl
	import ictrk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t stat,
	output ctrl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CMP   = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_OUT   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	// Next state and command decode
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_n    = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_n     = S_EXEC;
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_n     = stat.is_clear ? S_DRAIN : S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (stat.out_free) begin
					cmd.drain_step = 1'b1;
					if (stat.drain_last) begin
						state_n = S_IDLE;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

FILE: hdl/ictrk_dp.sv
// Datapath: request table, stream credit counters, configuration and result register.
`include "inflight_request_credit_tracker_assert.svh"
module ictrk_dp
	import ictrk_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned NUM_STREAMS = NUM_STREAMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            stat,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Accepted item
	logic [KIND_W-1:0]  item_kind_q;
	logic [FRAME_W-1:0] item_frame_q;
	logic [TAG_W-1:0]   item_tag_q;
	logic [MASK_W-1:0]  item_mask_q;
	logic               item_has_q;
	logic               item_want_q;

	// Configuration
	logic [NUM_STREAMS-1:0] cfg_mask_q;
	logic [LIMIT_W-1:0]     limit_q [NUM_STREAMS];

	// Table and credits
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [FRAME_W-1:0]     frame_q   [TABLE_DEPTH];
	logic [TAG_W-1:0]       tag_q     [TABLE_DEPTH];
	logic [MASK_W-1:0]      streams_q [TABLE_DEPTH];
	logic [COUNT_W-1:0]     count_q   [NUM_STREAMS];

	// Compare stage and execute results
	logic [TABLE_DEPTH-1:0] match_q;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic [MASK_W-1:0]      full_vec;
	logic                   blocked;
	logic [TAG_W-1:0]       sel_tag;
	logic [MASK_W-1:0]      sel_streams;
	logic [STATUS_W-1:0]    status_n;
	logic                   add_ok;
	logic                   remove_ok;
	logic                   clear_go;
	logic                   cfg_mask_wr;
	logic [STATUS_W-1:0]    res_status_q;
	logic                   res_inflight_q;

	// Drain walk
	logic [TABLE_DEPTH-1:0] pending_q;
	logic [TABLE_DEPTH-1:0] pending_rest;
	logic [DRAIN_CNT_W-1:0] drain_cnt_q;
	logic                   pend_any;
	logic [IDX_W-1:0]       low_idx;

	// Output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_inflight_q;
	logic                out_empty_q;
	logic                out_dvalid_q;
	logic [FRAME_W-1:0]  out_frame_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic                out_last_q;

	// Latch the accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_kind_q  <= KIND_ADD;
			item_frame_q <= '0;
			item_tag_q   <= '0;
			item_mask_q  <= '0;
			item_has_q   <= 1'b0;
			item_want_q  <= 1'b0;
		end else if (cmd.accept) begin
			item_kind_q  <= s_tuser;
			item_frame_q <= s_tdata[FRAME_W-1:0];
			item_tag_q   <= s_tdata[IN_TAG_LSB +: TAG_W];
			item_mask_q  <= s_tdata[IN_MASK_LSB +: MASK_W];
			item_has_q   <= s_tdata[IN_HAS_BIT];
			item_want_q  <= s_tdata[IN_WANT_BIT];
		end
	end

	// Configuration writes; bits above the stream count are dropped
	assign cfg_mask_wr = cfg_we && (cfg_index == CFG_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mask_q <= '0;
			for (int s = 0; s < NUM_STREAMS; s++) begin
				limit_q[s] <= '0;
			end
		end else begin
			if (cfg_mask_wr) begin
				cfg_mask_q <= cfg_wdata[NUM_STREAMS-1:0];
			end
			for (int s = 0; s < NUM_STREAMS; s++) begin
				if (cfg_we && (cfg_index == CFG_IDX_W'(int'(CFG_LIMIT0) + s))) begin
					limit_q[s] <= cfg_wdata[LIMIT_W-1:0];
				end
			end
		end
	end

	// Compare the frame against every live entry
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				match_q[i] <= valid_q[i] && (frame_q[i] == item_frame_q);
			end
		end
	end

	// Lowest match, lowest free slot, lowest pending drain entry
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		low_idx  = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			if (pending_q[i]) begin
				low_idx = IDX_W'(i);
			end
		end
	end

	assign hit        = |match_q;
	assign free_found = ~&valid_q;
	assign sel_tag     = tag_q[hit_idx];
	assign sel_streams = streams_q[hit_idx];

	// A stream is full when absent, unconfigured or at its limit
	for (genvar s = 0; s < MASK_W; s++) begin : g_full
		if (s < NUM_STREAMS) begin : g_real
			assign full_vec[s] = !cfg_mask_q[s] || (count_q[s] >= limit_q[s]);
		end else begin : g_absent
			assign full_vec[s] = 1'b1;
		end
	end
	assign blocked = |(item_mask_q & full_vec);

	// Decide the status of the item
	always_comb begin
		status_n = ST_OK;
		unique case (item_kind_q)
			KIND_ADD: begin
				priority if (hit) begin
					status_n = ST_DUPLICATE;
				end else if (blocked) begin
					status_n = ST_STREAM_FULL;
				end else if (!free_found) begin
					status_n = ST_TABLE_FULL;
				end else begin
					status_n = ST_OK;
				end
			end
			KIND_REMOVE: begin
				priority if (!item_has_q) begin
					status_n = ST_NO_REQUEST;
				end else if (!hit) begin
					status_n = ST_NOT_FOUND;
				end else if (sel_tag != item_tag_q) begin
					status_n = ST_TAG_MISMATCH;
				end else begin
					status_n = ST_OK;
				end
			end
			KIND_CLEAR: status_n = ST_OK;
			KIND_QUERY: status_n = ST_OK;
			default:    status_n = ST_OK;
		endcase
	end

	assign add_ok    = cmd.execute && (item_kind_q == KIND_ADD) && (status_n == ST_OK);
	assign remove_ok = cmd.execute && (item_kind_q == KIND_REMOVE) && (status_n == ST_OK);
	assign clear_go  = cmd.execute && (item_kind_q == KIND_CLEAR);

	// Update valid bits and drain set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			pending_q   <= '0;
			drain_cnt_q <= '0;
		end else begin
			if (clear_go) begin
				valid_q     <= '0;
				pending_q   <= item_want_q ? valid_q : '0;
				drain_cnt_q <= '0;
			end else if (add_ok) begin
				valid_q[free_idx] <= 1'b1;
			end else if (remove_ok) begin
				valid_q[hit_idx] <= 1'b0;
			end
			if (cmd.drain_step) begin
				pending_q   <= pending_rest;
				drain_cnt_q <= drain_cnt_q + 1'b1;
			end
		end
	end

	// Store a new entry
	always_ff @(posedge clk) begin
		if (add_ok) begin
			frame_q[free_idx]   <= item_frame_q;
			tag_q[free_idx]     <= item_tag_q;
			streams_q[free_idx] <= item_mask_q;
		end
	end

	// Take or return credits; zero on clear or mask write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STREAMS; s++) begin
				count_q[s] <= '0;
			end
		end else begin
			for (int s = 0; s < NUM_STREAMS; s++) begin
				priority if (cfg_mask_wr || clear_go) begin
					count_q[s] <= '0;
				end else if (add_ok && item_mask_q[s]) begin
					count_q[s] <= count_q[s] + 1'b1;
				end else if (remove_ok && sel_streams[s] && (count_q[s] != '0)) begin
					count_q[s] <= count_q[s] - 1'b1;
				end else begin
					count_q[s] <= count_q[s];
				end
			end
		end
	end

	// Hold the result of a single-result item
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_status_q   <= status_n;
			res_inflight_q <= (item_kind_q == KIND_QUERY) && hit;
		end
	end

	// Drain bookkeeping
	assign pend_any     = |pending_q;
	assign pending_rest = pending_q & (pending_q - 1'b1);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load || cmd.drain_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q   <= res_status_q;
			out_inflight_q <= res_inflight_q;
			out_empty_q    <= ~|valid_q;
			out_dvalid_q   <= 1'b0;
			out_frame_q    <= '0;
			out_tag_q      <= '0;
			out_last_q     <= 1'b1;
		end else if (cmd.drain_step) begin
			out_status_q   <= ST_OK;
			out_inflight_q <= 1'b0;
			out_empty_q    <= ~|valid_q;
			out_dvalid_q   <= pend_any;
			out_frame_q    <= pend_any ? frame_q[low_idx] : '0;
			out_tag_q      <= pend_any ? tag_q[low_idx] : '0;
			out_last_q     <= stat.drain_last;
		end
	end

	assign stat.is_clear   = (item_kind_q == KIND_CLEAR);
	assign stat.out_free   = !out_valid_q || m_tready;
	assign stat.drain_last = !pend_any || (pending_rest == '0) ||
		(drain_cnt_q == DRAIN_CNT_W'(MAX_RESULTS - 1));

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_dvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_tag_q, out_frame_q,
		out_empty_q, out_inflight_q, out_status_q};

	`ICT_ASSERT_NXT(a_clear_empties, clear_go, ~|valid_q, "clear left an entry valid")
	`ICT_ASSERT_NXT(a_add_fills, add_ok, |valid_q, "accepted add left the table empty")
	`ICT_ASSERT_IMP(a_drain_empty, out_valid_q && out_dvalid_q, out_empty_q && out_status_q == ST_OK, "drained entry with table not empty")
	`ICT_ASSERT_IMP(a_inflight_ok, out_valid_q && out_inflight_q, out_status_q == ST_OK && !out_dvalid_q, "in-flight flag on a bad result")

endmodule

FILE: hdl/inflight_request_credit_tracker.sv
// Top level of the credit-based in-flight request tracker.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | kind, frame, tag, mask, flags
//  m_*      | out       | m_tvalid/m_tready  | status, flags, drained entry, tlast
//  cfg_*    | in        | cfg_we             | register index and value
//
//  Add, remove and query each pass through accept, frame compare register, execute
//  and output register load; the load waits until the output register is free.
//  Clear passes through accept, compare and execute, then gives 1 to 16 results,
//  walking the table's drain set one entry per cycle while the output is free.
//  Reset empties the table, zeroes credits and configuration; no clearing pass.
//  The next item is accepted while a result waits in the output register; a
//  stalled output stops the sequencer before its next output load.
module inflight_request_credit_tracker
	import ictrk_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned NUM_STREAMS = NUM_STREAMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// frame, request_tag, stream_mask, has_request, want_list, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status, in_flight, empty_res, drained_frame, drained_tag, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// drained_valid
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// Sequencer
	ictrk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Table, credits and result register
	ictrk_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NUM_STREAMS (NUM_STREAMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule
